// ===== rtl/ctsc_pkg.sv =====
// Shared types, event codes and segment table for the clock time-setting controller.
// No dependencies; ctsc_evt_if, ctsc_step and the top level use this package.
package ctsc_pkg;

  localparam int FUNC_W = 3;

  localparam logic [FUNC_W-1:0] FUNC_IGNORE = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_SET    = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_INC    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_DEC    = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd4;

  localparam logic [7:0] HOURS_12H_FLAG = 8'h40;
  localparam logic [7:0] HOURS_TENS_BIT = 8'h10;
  localparam logic [7:0] SEG_DP         = 8'h80;
  localparam logic [7:0] SEG_BLANK      = 8'h00;

  typedef enum logic [1:0] {
    MODE_RUN   = 2'd0,
    MODE_HOURS = 2'd1,
    MODE_MTENS = 2'd2,
    MODE_MONES = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic       cur_hour_tens;
    logic [3:0] cur_hour_ones;
    logic [3:0] cur_minute_tens;
    logic [3:0] cur_minute_ones;
    logic [4:0] scratch_hours;
    logic [3:0] scratch_minute_tens;
    logic [3:0] scratch_minute_ones;
    logic       changed;
  } ctsc_state_t;

  typedef struct packed {
    logic [1:0]  mode_now;
    logic        write_request;
    logic [7:0]  write_minutes_byte;
    logic [7:0]  write_hours_byte;
    logic        redraw;
    logic        hour_tens_digit;
    logic [3:0]  hour_ones_digit;
    logic [3:0]  minute_tens_digit;
    logic [3:0]  minute_ones_digit;
    logic [7:0]  seg_set_hour_tens;
    logic [7:0]  seg_set_hour_ones;
    logic [15:0] seg_set_minutes;
  } ctsc_result_t;

  // Seven-segment code of one decimal digit; anything above nine is blank.
  function automatic logic [7:0] seg_of(input logic [4:0] d);
    logic [7:0] code;
    unique case (d)
      5'd0:    code = 8'h5F;
      5'd1:    code = 8'h06;
      5'd2:    code = 8'h3B;
      5'd3:    code = 8'h2F;
      5'd4:    code = 8'h66;
      5'd5:    code = 8'h6D;
      5'd6:    code = 8'h7D;
      5'd7:    code = 8'h07;
      5'd8:    code = 8'h7F;
      5'd9:    code = 8'h6F;
      default: code = SEG_BLANK;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/ctsc_evt_if.sv =====
// Event channel: valid/ready handshake carrying one controller event.
// Depends on ctsc_pkg for the event code width.
interface ctsc_evt_if;
  logic                         valid;
  logic                         ready;
  logic [ctsc_pkg::FUNC_W-1:0]  func;
  logic [7:0]                   read_minutes_byte;
  logic [7:0]                   read_hours_byte;

  modport source (output valid, func, read_minutes_byte, read_hours_byte, input ready);
  modport sink   (input valid, func, read_minutes_byte, read_hours_byte, output ready);
endinterface

// ===== rtl/ctsc_res_if.sv =====
// Result channel: valid/ready handshake carrying the state and display codes after an event.
// No package dependency; field widths are fixed.
interface ctsc_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode_now;
  logic        write_request;
  logic [7:0]  write_minutes_byte;
  logic [7:0]  write_hours_byte;
  logic        redraw;
  logic        hour_tens_digit;
  logic [3:0]  hour_ones_digit;
  logic [3:0]  minute_tens_digit;
  logic [3:0]  minute_ones_digit;
  logic [7:0]  seg_set_hour_tens;
  logic [7:0]  seg_set_hour_ones;
  logic [15:0] seg_set_minutes;

  modport source (output valid, mode_now, write_request, write_minutes_byte, write_hours_byte,
                  redraw, hour_tens_digit, hour_ones_digit, minute_tens_digit,
                  minute_ones_digit, seg_set_hour_tens, seg_set_hour_ones, seg_set_minutes,
                  input ready);
  modport sink   (input valid, mode_now, write_request, write_minutes_byte, write_hours_byte,
                  redraw, hour_tens_digit, hour_ones_digit, minute_tens_digit,
                  minute_ones_digit, seg_set_hour_tens, seg_set_hour_ones, seg_set_minutes,
                  output ready);
endinterface

// ===== rtl/ctsc_step.sv =====
// Combinational next-state and result logic for one event.
// Depends on ctsc_pkg for the state and result structs and the segment table.
module ctsc_step (
  input  ctsc_pkg::ctsc_state_t              state,
  input  logic [ctsc_pkg::FUNC_W-1:0]        func,
  input  logic [7:0]                         read_minutes_byte,
  input  logic [7:0]                         read_hours_byte,
  output ctsc_pkg::ctsc_state_t              state_next,
  output ctsc_pkg::ctsc_result_t             result
);
  import ctsc_pkg::*;

  logic [4:0] sh;
  logic [7:0] wr_hours;
  logic [7:0] wr_minutes;
  logic       wr_req;
  logic       take;
  logic [7:0] take_mb;
  logic [7:0] take_hb;
  logic [4:0] nh;
  logic [4:0] nh_ones;

  assign sh         = state.scratch_hours;
  assign wr_minutes = {state.scratch_minute_tens, state.scratch_minute_ones};
  assign wr_hours   = (sh >= 5'd10) ?
                      ((HOURS_12H_FLAG | HOURS_TENS_BIT) | ({3'b000, sh} - 8'd10)) :
                      (HOURS_12H_FLAG | {3'b000, sh});

  always_comb begin
    state_next = state;
    wr_req     = 1'b0;
    take       = 1'b0;
    take_mb    = read_minutes_byte;
    take_hb    = read_hours_byte;
    unique case (func)
      FUNC_SET: begin
        unique case (state.mode)
          MODE_RUN: begin
            state_next.mode                = MODE_HOURS;
            state_next.scratch_minute_tens = state.cur_minute_tens;
            state_next.scratch_minute_ones = state.cur_minute_ones;
            state_next.scratch_hours       = (state.cur_hour_tens ? 5'd10 : 5'd0) +
                                             {1'b0, state.cur_hour_ones};
          end
          MODE_HOURS: state_next.mode = MODE_MTENS;
          MODE_MTENS: state_next.mode = MODE_MONES;
          MODE_MONES: begin
            // The written time is taken as current without waiting for a read-back.
            state_next.mode = MODE_RUN;
            wr_req          = 1'b1;
            take            = 1'b1;
            take_mb         = wr_minutes;
            take_hb         = wr_hours;
          end
          default: state_next.mode = state.mode;
        endcase
      end
      FUNC_INC: begin
        unique case (state.mode)
          MODE_HOURS: state_next.scratch_hours = (sh >= 5'd12) ? 5'd1 : sh + 5'd1;
          MODE_MTENS: state_next.scratch_minute_tens = (state.scratch_minute_tens >= 4'd5) ?
                                                       4'd0 : state.scratch_minute_tens + 4'd1;
          MODE_MONES: state_next.scratch_minute_ones = (state.scratch_minute_ones >= 4'd9) ?
                                                       4'd0 : state.scratch_minute_ones + 4'd1;
          default: state_next.scratch_hours = sh;
        endcase
      end
      FUNC_DEC: begin
        unique case (state.mode)
          MODE_HOURS: state_next.scratch_hours = (sh <= 5'd1 || sh > 5'd12) ? 5'd12 : sh - 5'd1;
          MODE_MTENS: state_next.scratch_minute_tens =
                        (state.scratch_minute_tens == 4'd0 || state.scratch_minute_tens > 4'd5) ?
                        4'd5 : state.scratch_minute_tens - 4'd1;
          MODE_MONES: state_next.scratch_minute_ones =
                        (state.scratch_minute_ones == 4'd0 || state.scratch_minute_ones > 4'd9) ?
                        4'd9 : state.scratch_minute_ones - 4'd1;
          default: state_next.scratch_hours = sh;
        endcase
      end
      FUNC_READ: take = 1'b1;
      default:   take = 1'b0;
    endcase

    if (take) begin
      state_next.cur_minute_tens = take_mb[7:4];
      state_next.cur_minute_ones = take_mb[3:0];
      state_next.cur_hour_tens   = take_hb[4];
      state_next.cur_hour_ones   = take_hb[3:0];
      // A finished set always forces a redraw.
      state_next.changed = wr_req ||
                           take_mb[7:4] != state.cur_minute_tens ||
                           take_mb[3:0] != state.cur_minute_ones ||
                           take_hb[4]   != state.cur_hour_tens ||
                           take_hb[3:0] != state.cur_hour_ones;
    end
  end

  assign nh      = state_next.scratch_hours;
  assign nh_ones = (nh >= 5'd10) ? nh - 5'd10 : nh;

  always_comb begin
    result.mode_now           = state_next.mode;
    result.write_request      = wr_req;
    result.write_minutes_byte = wr_req ? wr_minutes : 8'h00;
    result.write_hours_byte   = wr_req ? wr_hours : 8'h00;
    result.redraw             = (state_next.mode != MODE_RUN) || state_next.changed;
    result.hour_tens_digit    = state_next.cur_hour_tens;
    result.hour_ones_digit    = state_next.cur_hour_ones;
    result.minute_tens_digit  = state_next.cur_minute_tens;
    result.minute_ones_digit  = state_next.cur_minute_ones;
    result.seg_set_hour_tens  = (nh >= 5'd10) ? seg_of(5'd1) : SEG_BLANK;
    result.seg_set_hour_ones  = seg_of(nh_ones) | SEG_DP;
    result.seg_set_minutes    = {seg_of({1'b0, state_next.scratch_minute_tens}),
                                 seg_of({1'b0, state_next.scratch_minute_ones})};
  end

endmodule

// ===== rtl/clock_time_setting_controller.sv =====
// Top level of the clock time-setting controller: input register, state registers and result
// register around ctsc_step. Depends on ctsc_pkg, ctsc_evt_if, ctsc_res_if and ctsc_step.
//
// One event request is taken every clock cycle while the input register is free or advancing,
// and each gives exactly one result request. An event is held in the input register, then
// ctsc_step works out the new state and the display codes, which land in the result register
// together with the state update. The result register stalls only the input register behind
// it: while a result waits to be taken, one more event is still accepted.
module clock_time_setting_controller (
  input logic       clk,
  input logic       rst,
  ctsc_evt_if.sink   evt,
  ctsc_res_if.source res
);
  import ctsc_pkg::*;

  logic                s1_valid;
  logic [FUNC_W-1:0]   s1_func;
  logic [7:0]          s1_minutes;
  logic [7:0]          s1_hours;
  logic                advance;
  logic                out_valid;
  ctsc_state_t         state;
  ctsc_state_t         state_next;
  ctsc_result_t        result_next;
  ctsc_result_t        result;

  assign advance   = s1_valid && (!out_valid || res.ready);
  assign evt.ready = !s1_valid || advance;

  ctsc_step u_step (
    .state             (state),
    .func              (s1_func),
    .read_minutes_byte (s1_minutes),
    .read_hours_byte   (s1_hours),
    .state_next        (state_next),
    .result            (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= '0;
    end else begin
      if (evt.valid && evt.ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
        state     <= state_next;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (evt.valid && evt.ready) begin
      s1_func    <= evt.func;
      s1_minutes <= evt.read_minutes_byte;
      s1_hours   <= evt.read_hours_byte;
    end
    if (advance) begin
      result <= result_next;
    end
  end

  assign res.valid              = out_valid;
  assign res.mode_now           = result.mode_now;
  assign res.write_request      = result.write_request;
  assign res.write_minutes_byte = result.write_minutes_byte;
  assign res.write_hours_byte   = result.write_hours_byte;
  assign res.redraw             = result.redraw;
  assign res.hour_tens_digit    = result.hour_tens_digit;
  assign res.hour_ones_digit    = result.hour_ones_digit;
  assign res.minute_tens_digit  = result.minute_tens_digit;
  assign res.minute_ones_digit  = result.minute_ones_digit;
  assign res.seg_set_hour_tens  = result.seg_set_hour_tens;
  assign res.seg_set_hour_ones  = result.seg_set_hour_ones;
  assign res.seg_set_minutes    = result.seg_set_minutes;

`ifndef SYNTHESIS
  // A write request ends the set sequence and always asks for a redraw.
  a_write_ends_set: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.write_request |-> result.mode_now == MODE_RUN && result.redraw)
    else $error("write request without return to clock mode");

  // The time taken as current is the time written to the clock chip.
  a_write_is_current: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.write_request |->
      result.hour_ones_digit == result.write_hours_byte[3:0] &&
      result.hour_tens_digit == result.write_hours_byte[4] &&
      result.minute_tens_digit == result.write_minutes_byte[7:4] &&
      result.minute_ones_digit == result.write_minutes_byte[3:0] &&
      result.write_hours_byte[6])
    else $error("current time differs from written time");

  // Any set mode keeps the display redrawing.
  a_set_redraws: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.mode_now != MODE_RUN |-> result.redraw)
    else $error("set mode without redraw");

  // The state only moves when a result is produced.
  a_state_on_advance: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state))
    else $error("state changed without an event");

  // A held event reaches the result register before a new one replaces it.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |-> !evt.ready)
    else $error("input register would be overwritten");
`endif

endmodule
